### hdl/indexed_list_insert_remove_assert.svh
// Assertion macros for the indexed list checker.
// Both expect signals named clock and reset in the scope of use.
`ifndef INDEXED_LIST_INSERT_REMOVE_ASSERT_SVH
`define INDEXED_LIST_INSERT_REMOVE_ASSERT_SVH

// Same-cycle implication.
`define ILIR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ILIR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/ilir_pkg.sv
package ilir_pkg;

   // Fixed field widths of the request and response channels
   localparam int ACTION_W   = 3;
   localparam int POSITION_W = 4;
   localparam int DATA_W     = 32;
   localparam int COUNT_W    = 5;
   localparam int STATUS_W   = 2;

   // Defaults for the top-level parameters
   localparam int DEFAULT_DEPTH = 16;
   localparam int DEFAULT_WIDTH = 32;

   typedef enum logic [ACTION_W-1:0] {
      ACT_GET    = 3'd0,
      ACT_WRITE  = 3'd1,
      ACT_APPEND = 3'd2,
      ACT_POP    = 3'd3,
      ACT_INSERT = 3'd4,
      ACT_REMOVE = 3'd5,
      ACT_CLEAR  = 3'd6
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_INDEX = 2'd1,
      ST_FULL  = 2'd2,
      ST_EMPTY = 2'd3
   } status_type;

   // What every cell does at the next edge, relative to the target slot
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,  // keep contents
      CELL_LOAD   = 2'd1,  // target takes new data
      CELL_INSERT = 2'd2,  // target takes new data, cells above take left neighbour
      CELL_REMOVE = 2'd3   // target and cells above take right neighbour
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
   } cell_ctrl_type;

endpackage

### hdl/ilir_req_if.sv
interface ilir_req_if;
   logic                             valid;
   logic                             ready;
   logic [ilir_pkg::ACTION_W-1:0]    action;
   logic [ilir_pkg::POSITION_W-1:0]  position;
   logic [ilir_pkg::DATA_W-1:0]      entry_in;

   modport source (output valid, output action, output position, output entry_in,
                   input ready);
   modport sink   (input valid, input action, input position, input entry_in,
                   output ready);
endinterface

### hdl/ilir_rsp_if.sv
interface ilir_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [ilir_pkg::DATA_W-1:0]     entry_out;
   logic [ilir_pkg::COUNT_W-1:0]    count;
   logic [ilir_pkg::STATUS_W-1:0]   status;

   modport source (output valid, output entry_out, output count, output status,
                   input ready);
   modport sink   (input valid, input entry_out, input count, input status,
                   output ready);
endinterface

### hdl/ilir_cell.sv
// One list slot. Knows its own index and reacts to the broadcast op and target.
module ilir_cell #(
   parameter int WIDTH = ilir_pkg::DEFAULT_WIDTH,
   parameter int IW    = 4,
   parameter int INDEX = 0
) (
   input  logic                    clock,
   input  ilir_pkg::cell_ctrl_type ctrl,
   input  logic [IW-1:0]           target,
   input  logic [WIDTH-1:0]        load_data,
   input  logic [WIDTH-1:0]        left_data,
   input  logic [WIDTH-1:0]        right_data,
   output logic [WIDTH-1:0]        entry_q,
   output logic [WIDTH-1:0]        sel_data
);

   logic [WIDTH-1:0] entry_ff;
   logic [WIDTH-1:0] entry_in;
   logic             hit;
   logic             above;

   assign hit   = (target == IW'(INDEX));
   assign above = (IW'(INDEX) > target);

   always_comb begin
      unique case (ctrl.op)
         ilir_pkg::CELL_HOLD:   entry_in = entry_ff;
         ilir_pkg::CELL_LOAD:   entry_in = hit ? load_data : entry_ff;
         ilir_pkg::CELL_INSERT: entry_in = hit ? load_data : (above ? left_data : entry_ff);
         ilir_pkg::CELL_REMOVE: entry_in = (hit || above) ? right_data : entry_ff;
         default:               entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_q  = entry_ff;
   assign sel_data = hit ? entry_ff : '0;

endmodule

### hdl/indexed_list_insert_remove.sv
// Bounded ordered list of DEPTH entries of WIDTH bits with a length counter. Each request is
// one action (get, write, append, pop, insert, remove, clear) and yields exactly one response
// carrying the entry read or removed, the length after the action and a status (ok, index out
// of range, list full, list empty); a flagged action changes nothing. The store is a row of
// DEPTH cells: insert moves every cell above the target up by one and remove moves them down
// by one, all in the same clock, so every action finishes in the cycle it is accepted. A
// request is taken every clock as long as the response register is empty or being drained,
// and its response appears in the cycle after acceptance, held in the single response
// register. Indexes come from the 4-bit position field, so get, write, insert and remove
// reach the first 16 slots; append and pop reach all of them. Entries are not cleared at
// reset and clear only zeroes the length; reading is only ever done below the length, which
// always covers written slots. The count field shows the low 5 bits of the length.
module indexed_list_insert_remove #(
   parameter int DEPTH = ilir_pkg::DEFAULT_DEPTH,
   parameter int WIDTH = ilir_pkg::DEFAULT_WIDTH
) (
   input  logic            clock,
   input  logic            reset,
   ilir_req_if.sink        req_chan,
   ilir_rsp_if.source      rsp_chan
);

   // index, length and compare widths
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW = $clog2(DEPTH + 1);
   localparam int CW = (FW > ilir_pkg::POSITION_W) ? FW : ilir_pkg::POSITION_W;

   // length register
   logic [FW-1:0] fill_ff;
   logic [FW-1:0] fill_in;

   // response register
   logic                             rsp_valid_ff;
   logic [ilir_pkg::DATA_W-1:0]      entry_out_ff;
   logic [ilir_pkg::COUNT_W-1:0]     count_ff;
   ilir_pkg::status_type             status_ff;
   logic [ilir_pkg::DATA_W-1:0]      entry_out_in;
   logic [ilir_pkg::COUNT_W-1:0]     count_in;
   ilir_pkg::status_type             status_in;

   // request decode
   logic                   req_fire;
   ilir_pkg::action_type   action;
   logic [CW-1:0]          pos_c;
   logic [CW-1:0]          fill_c;
   logic [CW-1:0]          tgt_c;
   logic [IW-1:0]          target;
   ilir_pkg::cell_ctrl_type ctrl;
   ilir_pkg::cell_op_type  op;
   logic                   take_read;
   logic [63:0]            in_wide;
   logic [WIDTH-1:0]       load_data;
   logic [WIDTH-1:0]       read_data;
   logic [63:0]            read_wide;
   logic [15:0]            fill_wide;

   // cell row
   logic [WIDTH-1:0] cell_q   [DEPTH];
   logic [WIDTH-1:0] cell_sel [DEPTH];

   // accept while the response slot is free or being emptied this cycle
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign action    = ilir_pkg::action_type'(req_chan.action);
   assign pos_c     = CW'(req_chan.position);
   assign fill_c    = CW'(fill_ff);
   assign in_wide   = 64'(req_chan.entry_in);
   assign load_data = in_wide[WIDTH-1:0];

   // Decide status, new length and the row operation. Only in-range targets get used,
   // so cutting the compare-width target down to IW bits loses nothing.
   always_comb begin
      op        = ilir_pkg::CELL_HOLD;
      tgt_c     = pos_c;
      fill_in   = fill_ff;
      status_in = ilir_pkg::ST_OK;
      take_read = 1'b0;
      unique case (action)
         ilir_pkg::ACT_GET: begin
            if (pos_c < fill_c) take_read = 1'b1;
            else                status_in = ilir_pkg::ST_INDEX;
         end
         ilir_pkg::ACT_WRITE: begin
            if (pos_c < fill_c) op = ilir_pkg::CELL_LOAD;
            else                status_in = ilir_pkg::ST_INDEX;
         end
         ilir_pkg::ACT_APPEND: begin
            tgt_c = fill_c;
            if (fill_c < CW'(DEPTH)) begin
               op      = ilir_pkg::CELL_LOAD;
               fill_in = fill_ff + FW'(1);
            end else begin
               status_in = ilir_pkg::ST_FULL;
            end
         end
         ilir_pkg::ACT_POP: begin
            tgt_c = fill_c - CW'(1);
            if (fill_ff != '0) begin
               take_read = 1'b1;
               fill_in   = fill_ff - FW'(1);
            end else begin
               status_in = ilir_pkg::ST_EMPTY;
            end
         end
         ilir_pkg::ACT_INSERT: begin
            // range is checked before capacity
            priority if (pos_c > fill_c) begin
               status_in = ilir_pkg::ST_INDEX;
            end else if (fill_c >= CW'(DEPTH)) begin
               status_in = ilir_pkg::ST_FULL;
            end else begin
               op      = ilir_pkg::CELL_INSERT;
               fill_in = fill_ff + FW'(1);
            end
         end
         ilir_pkg::ACT_REMOVE: begin
            priority if (fill_ff == '0) begin
               status_in = ilir_pkg::ST_EMPTY;
            end else if (pos_c >= fill_c) begin
               status_in = ilir_pkg::ST_INDEX;
            end else begin
               take_read = 1'b1;
               op        = ilir_pkg::CELL_REMOVE;
               fill_in   = fill_ff - FW'(1);
            end
         end
         ilir_pkg::ACT_CLEAR: begin
            fill_in = '0;
         end
         default: begin
            // unused code: nothing happens, status ok
         end
      endcase
   end

   assign target  = tgt_c[IW-1:0];
   assign ctrl.op = req_fire ? op : ilir_pkg::CELL_HOLD;

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic [WIDTH-1:0] left_data;
         logic [WIDTH-1:0] right_data;
         if (gi == 0) begin : g_first
            assign left_data = '0;
         end else begin : g_mid_l
            assign left_data = cell_q[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_last
            assign right_data = '0;
         end else begin : g_mid_r
            assign right_data = cell_q[gi+1];
         end
         ilir_cell #(
            .WIDTH (WIDTH),
            .IW    (IW),
            .INDEX (gi)
         ) u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .target     (target),
            .load_data  (load_data),
            .left_data  (left_data),
            .right_data (right_data),
            .entry_q    (cell_q[gi]),
            .sel_data   (cell_sel[gi])
         );
      end
   endgenerate

   // only the target cell drives its contents; OR them together
   always_comb begin
      read_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         read_data = read_data | cell_sel[i];
      end
   end

   assign read_wide    = 64'(read_data);
   assign entry_out_in = take_read ? read_wide[ilir_pkg::DATA_W-1:0] : '0;
   assign fill_wide    = 16'(fill_in);
   assign count_in     = fill_wide[ilir_pkg::COUNT_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            fill_ff <= fill_in;
         end
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response payload, no reset needed
   always_ff @(posedge clock) begin
      if (req_fire) begin
         entry_out_ff <= entry_out_in;
         count_ff     <= count_in;
         status_ff    <= status_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.entry_out = entry_out_ff;
   assign rsp_chan.count     = count_ff;
   assign rsp_chan.status    = status_ff;

endmodule

### hdl/ilir_checker.sv
`include "indexed_list_insert_remove_assert.svh"

module ilir_checker #(
   parameter int DEPTH = ilir_pkg::DEFAULT_DEPTH
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic [ilir_pkg::DATA_W-1:0]      rsp_entry_out,
   input logic [ilir_pkg::COUNT_W-1:0]     rsp_count,
   input logic [ilir_pkg::STATUS_W-1:0]    rsp_status
);

   localparam logic [ilir_pkg::COUNT_W-1:0] FULL_COUNT = ilir_pkg::COUNT_W'(DEPTH);
   localparam logic SMALL_LIST = (DEPTH < 32);

   // a stalled response keeps its payload
   `ILIR_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_entry_out) && $stable(rsp_count) && $stable(rsp_status), "stalled response changed")

   // every accepted request shows a response on the next cycle
   `ILIR_ASSERT_NEXT(a_req_to_rsp, req_valid && req_ready, rsp_valid, "accepted request gave no response")

   // an empty-list flag carries a zero length and no entry
   `ILIR_ASSERT_NOW(a_empty_zero, rsp_valid && (rsp_status == ilir_pkg::ST_EMPTY), (rsp_count == '0) && (rsp_entry_out == '0), "empty flag with data")

   // a full-list flag only with the length at capacity (checked when DEPTH is below 32)
   `ILIR_ASSERT_NOW(a_full_count, rsp_valid && SMALL_LIST && (rsp_status == ilir_pkg::ST_FULL), rsp_count == FULL_COUNT, "full flag below capacity")

endmodule

bind indexed_list_insert_remove ilir_checker #(.DEPTH(DEPTH)) u_ilir_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_entry_out (rsp_chan.entry_out),
   .rsp_count     (rsp_chan.count),
   .rsp_status    (rsp_chan.status)
);

### tb/indexed_list_insert_remove_checker.sv
`timescale 1ns / 1ps

// Watches both channels, keeps a shadow of the list and checks every response
// against the one predicted for the oldest outstanding request.
module indexed_list_insert_remove_checker (
   input  logic  clock,
   input  logic  reset,
   ilir_req_if   req_bus,
   ilir_rsp_if   rsp_bus,
   output int    fail_count,
   output int    pending_count
);

   localparam int SLOTS = ilir_pkg::DEFAULT_DEPTH;

   typedef struct packed {
      logic [ilir_pkg::DATA_W-1:0]   entry;
      logic [ilir_pkg::COUNT_W-1:0]  count;
      logic [ilir_pkg::STATUS_W-1:0] status;
   } list_reply_type;

   logic [ilir_pkg::DATA_W-1:0] shadow_entries [SLOTS];
   int                          shadow_fill;
   list_reply_type              replies_due [$];
   int                          mismatches;

   initial begin
      mismatches  = 0;
      shadow_fill = 0;
      foreach (shadow_entries[i]) shadow_entries[i] = '0;
   end

   // Applies one action to the shadow list and returns the response it gives.
   function automatic list_reply_type apply_action(
         logic [ilir_pkg::ACTION_W-1:0]   act,
         logic [ilir_pkg::POSITION_W-1:0] pos,
         logic [ilir_pkg::DATA_W-1:0]     val);
      list_reply_type r;
      int             p;
      p        = int'(pos);
      r.entry  = '0;
      r.status = ilir_pkg::ST_OK;
      case (act)
         ilir_pkg::ACT_GET: begin
            if (p < shadow_fill) r.entry = shadow_entries[p];
            else r.status = ilir_pkg::ST_INDEX;
         end
         ilir_pkg::ACT_WRITE: begin
            if (p < shadow_fill) shadow_entries[p] = val;
            else r.status = ilir_pkg::ST_INDEX;
         end
         ilir_pkg::ACT_APPEND: begin
            if (shadow_fill < SLOTS) begin
               shadow_entries[shadow_fill] = val;
               shadow_fill++;
            end else r.status = ilir_pkg::ST_FULL;
         end
         ilir_pkg::ACT_POP: begin
            if (shadow_fill > 0) begin
               shadow_fill--;
               r.entry = shadow_entries[shadow_fill];
            end else r.status = ilir_pkg::ST_EMPTY;
         end
         ilir_pkg::ACT_INSERT: begin
            // index is judged before fullness
            if (p > shadow_fill) r.status = ilir_pkg::ST_INDEX;
            else if (shadow_fill >= SLOTS) r.status = ilir_pkg::ST_FULL;
            else begin
               for (int i = shadow_fill; i > p; i--)
                  shadow_entries[i] = shadow_entries[i-1];
               shadow_entries[p] = val;
               shadow_fill++;
            end
         end
         ilir_pkg::ACT_REMOVE: begin
            if (shadow_fill == 0) r.status = ilir_pkg::ST_EMPTY;
            else if (p >= shadow_fill) r.status = ilir_pkg::ST_INDEX;
            else begin
               r.entry = shadow_entries[p];
               shadow_fill--;
               for (int i = p; i < shadow_fill; i++)
                  shadow_entries[i] = shadow_entries[i+1];
            end
         end
         ilir_pkg::ACT_CLEAR: shadow_fill = 0;
         default: ;
      endcase
      r.count = shadow_fill[ilir_pkg::COUNT_W-1:0];
      return r;
   endfunction

   always @(posedge clock) begin
      list_reply_type got;
      list_reply_type want;
      if (reset) begin
         shadow_fill = 0;
         replies_due.delete();
      end else begin
         // response first: a request taken at this edge is answered through the response register, never at this edge
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.entry  = rsp_bus.entry_out;
            got.count  = rsp_bus.count;
            got.status = rsp_bus.status;
            if (replies_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"%0t: response with no request outstanding: ",
                            "entry %h count %0d status %0d"},
                           $realtime, got.entry, got.count, got.status);
            end else begin
               want = replies_due.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%0t: mismatch: expected entry %h count %0d status %0d, ",
                               "got entry %h count %0d status %0d"},
                              $realtime, want.entry, want.count, want.status,
                              got.entry, got.count, got.status);
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            replies_due.push_back(apply_action(req_bus.action, req_bus.position,
                                               req_bus.entry_in));
      end
      fail_count    <= mismatches;
      pending_count <= replies_due.size();
   end

endmodule

### tb/indexed_list_insert_remove_test.sv
`timescale 1ns / 1ps

// Top of the list testbench: clock, reset, request stimulus, response-side
// back-pressure and the verdict. Prediction lives in the checker.
module indexed_list_insert_remove_test;

   // action code outside the defined set: must be a no-op returning ok
   localparam logic [ilir_pkg::ACTION_W-1:0] ACT_UNUSED = 3'd7;

   localparam int RANDOM_REQUESTS = 1800;
   localparam int CALM_TAIL       = 300;     // final requests run with no idling
   localparam int CYCLE_LIMIT     = 200000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   int   cycle_count = 0;
   bit   idle_en;

   ilir_req_if req_bus ();
   ilir_rsp_if rsp_bus ();

   indexed_list_insert_remove u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   indexed_list_insert_remove_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // 2 ns clock
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Watchdog: any hang ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Response side: ready drops in random bursts while idling is on.
   initial begin
      int hold_left;
      hold_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (idle_en && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left = $urandom_range(0, 2);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Present one request from a falling edge and hold it until it is taken.
   // Returns at the falling edge after acceptance.
   task automatic send_request(logic [ilir_pkg::ACTION_W-1:0]   act,
                               logic [ilir_pkg::POSITION_W-1:0] pos,
                               logic [ilir_pkg::DATA_W-1:0]     val);
      if (idle_en && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.action   <= act;
      req_bus.position <= pos;
      req_bus.entry_in <= val;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
   endtask

   // Entry values: plenty of all-zero and all-one words beside random ones.
   function automatic logic [ilir_pkg::DATA_W-1:0] pick_entry();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Action mix: grow_pct steers how often structural actions add rather
   // than take away, so phases alternate between filling and draining.
   function automatic logic [ilir_pkg::ACTION_W-1:0] pick_action(int grow_pct);
      int r;
      r = $urandom_range(0, 99);
      if (r < 2)  return ilir_pkg::ACT_CLEAR;
      if (r < 4)  return ACT_UNUSED;
      if (r < 28) return ilir_pkg::ACT_GET;
      if (r < 42) return ilir_pkg::ACT_WRITE;
      if ($urandom_range(0, 99) < grow_pct)
         return ($urandom_range(0, 1) == 0) ? ilir_pkg::ACT_APPEND : ilir_pkg::ACT_INSERT;
      return ($urandom_range(0, 1) == 0) ? ilir_pkg::ACT_POP : ilir_pkg::ACT_REMOVE;
   endfunction

   initial begin
      int grow_pct;
      logic [ilir_pkg::POSITION_W-1:0] pos;

      idle_en          = 1'b1;
      req_bus.valid    = 1'b0;
      req_bus.action   = ilir_pkg::ACT_GET;
      req_bus.position = '0;
      req_bus.entry_in = '0;
      reset            = 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed part ----
      // empty list: every read, write and removal is refused
      send_request(ilir_pkg::ACT_CLEAR,  4'd0,  '0);
      send_request(ilir_pkg::ACT_GET,    4'd0,  '0);
      send_request(ilir_pkg::ACT_WRITE,  4'd0,  '1);
      send_request(ilir_pkg::ACT_POP,    4'd0,  '0);
      send_request(ilir_pkg::ACT_REMOVE, 4'd0,  '0);
      send_request(ilir_pkg::ACT_INSERT, 4'd1,  32'h0000_0001);   // past the end
      // build up a few entries with insert at head, tail and middle
      send_request(ilir_pkg::ACT_INSERT, 4'd0,  32'hFFFF_FFFF);
      send_request(ilir_pkg::ACT_APPEND, 4'd0,  32'h0000_0000);
      send_request(ilir_pkg::ACT_INSERT, 4'd2,  32'h8000_0001);   // insert exactly at the end
      send_request(ilir_pkg::ACT_INSERT, 4'd1,  32'h1234_5678);
      send_request(ilir_pkg::ACT_WRITE,  4'd3,  32'hA5A5_5A5A);
      send_request(ilir_pkg::ACT_GET,    4'd1,  '0);
      send_request(ilir_pkg::ACT_REMOVE, 4'd1,  '0);
      send_request(ilir_pkg::ACT_REMOVE, 4'd3,  '0);              // past the end, non-empty
      send_request(ACT_UNUSED,           4'd15, '1);
      // fill to capacity (3 entries held now)
      repeat (ilir_pkg::DEFAULT_DEPTH - 3)
         send_request(ilir_pkg::ACT_APPEND, 4'd0, pick_entry());
      send_request(ilir_pkg::ACT_APPEND, 4'd0,  '1);              // full
      send_request(ilir_pkg::ACT_INSERT, 4'd15, '1);              // full
      send_request(ilir_pkg::ACT_GET,    4'd15, '0);
      send_request(ilir_pkg::ACT_REMOVE, 4'd15, '0);
      send_request(ilir_pkg::ACT_POP,    4'd0,  '0);
      send_request(ilir_pkg::ACT_INSERT, 4'd15, '0);              // past the end at 14 entries
      send_request(ilir_pkg::ACT_CLEAR,  4'd0,  '0);

      // ---- random part ----
      grow_pct = 50;
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 60 == 0)
            case ($urandom_range(0, 2))
               0:       grow_pct = 85;
               1:       grow_pct = 15;
               default: grow_pct = 50;
            endcase
         idle_en = (n < RANDOM_REQUESTS - CALM_TAIL);
         // hold the sender off once until the block has answered everything
         if (n == RANDOM_REQUESTS / 2) begin
            req_bus.valid <= 1'b0;
            wait (pending_count == 0);
            @(negedge clock);
         end
         pos = ($urandom_range(0, 4) < 3) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(0, 3));
         send_request(pick_action(grow_pct), pos, pick_entry());
      end
      req_bus.valid <= 1'b0;

      // drain, then let the registered failure count settle before the verdict
      wait (pending_count == 0);
      repeat (4) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+hdl
hdl/ilir_pkg.sv
hdl/ilir_req_if.sv
hdl/ilir_rsp_if.sv
hdl/ilir_cell.sv
hdl/indexed_list_insert_remove.sv
hdl/ilir_checker.sv
tb/indexed_list_insert_remove_checker.sv
tb/indexed_list_insert_remove_test.sv
